// ===== rtl/core/dfrs_pkg.sv =====
// shared types and constants for the decoder feed recovery supervisor
package dfrs_pkg;

    localparam int unsigned FEED_W     = 2;
    localparam int unsigned TIME_W     = 32;
    localparam int unsigned FRAMES_W   = 16;
    localparam int unsigned FPS_W      = 8;
    localparam int unsigned INTERVAL_W = 16;
    localparam int unsigned ERR_W      = 2;
    localparam int unsigned APB_ADDR_W = 4;
    localparam int unsigned APB_DATA_W = 32;
    localparam int unsigned REG_IDX_W  = 2;
    localparam int unsigned S_USER_W   = 3;
    localparam int unsigned M_DATA_W   = 8;

    // threshold product: fps * interval + rounding, and (frames + 1) * 1000
    localparam int unsigned PROD_W     = 24;
    localparam int unsigned SCALE_W    = 27;

    // feed result codes
    localparam logic [FEED_W-1:0] FEED_OK        = 2'd0;
    localparam logic [FEED_W-1:0] FEED_KEY_REQ   = 2'd1;
    localparam logic [FEED_W-1:0] FEED_NOT_READY = 2'd2;
    localparam logic [FEED_W-1:0] FEED_ERROR     = 2'd3;

    // register indexes (byte address / 4)
    localparam logic [REG_IDX_W-1:0] REG_STREAM_IS_HEVC      = 2'd0;
    localparam logic [REG_IDX_W-1:0] REG_TARGET_RATE_FPS     = 2'd1;
    localparam logic [REG_IDX_W-1:0] REG_REFRESH_INTERVAL_MS = 2'd2;

    localparam logic [FPS_W-1:0]      FPS_RESET      = 8'd60;
    localparam logic [ERR_W-1:0]      ERROR_LIMIT    = 2'd3;
    localparam logic [TIME_W-1:0]     ERROR_WINDOW_MS = 32'd2000;
    localparam logic [TIME_W-1:0]     WEDGE_MS       = 32'd5000;
    localparam logic [TIME_W-1:0]     KEY_GAP_MS     = 32'd1000;
    localparam logic [INTERVAL_W-1:0] MIN_REFRESH_MS = 16'd500;
    localparam logic [PROD_W-1:0]     ROUND_MS       = 24'd500;
    localparam logic [PROD_W-1:0]     MS_PER_S       = 24'd1000;
    localparam logic [FRAMES_W-1:0]   FRAMES_MAX     = 16'hFFFF;

    typedef struct packed {
        logic                  stream_is_hevc;
        logic [FPS_W-1:0]      target_rate_fps;
        logic [INTERVAL_W-1:0] refresh_interval_ms;
    } dfrs_cfg_t;

    typedef struct packed {
        logic reply;
        logic refresh_request;
        logic interrupt_session;
    } dfrs_result_t;

endpackage

// ===== rtl/core/dfrs_regs.sv =====
// apb configuration registers of the supervisor
module dfrs_regs (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [dfrs_pkg::APB_ADDR_W-1:0]   paddr,
    input  logic [dfrs_pkg::APB_DATA_W-1:0]   pwdata,
    output logic [dfrs_pkg::APB_DATA_W-1:0]   prdata,
    output logic                              pready,
    output dfrs_pkg::dfrs_cfg_t               cfg
);

    dfrs_pkg::dfrs_cfg_t            cfg_reg;
    logic [dfrs_pkg::REG_IDX_W-1:0] reg_idx;
    logic                           wr_en;

    assign reg_idx = paddr[dfrs_pkg::APB_ADDR_W-1:2];
    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite && pready;
    assign cfg     = cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.stream_is_hevc      <= 1'b0;
            cfg_reg.target_rate_fps     <= dfrs_pkg::FPS_RESET;
            cfg_reg.refresh_interval_ms <= '0;
        end else if (wr_en) begin
            unique case (reg_idx)
                dfrs_pkg::REG_STREAM_IS_HEVC: begin
                    cfg_reg.stream_is_hevc <= pwdata[0];
                end
                dfrs_pkg::REG_TARGET_RATE_FPS: begin
                    cfg_reg.target_rate_fps <= pwdata[dfrs_pkg::FPS_W-1:0];
                end
                dfrs_pkg::REG_REFRESH_INTERVAL_MS: begin
                    cfg_reg.refresh_interval_ms <= pwdata[dfrs_pkg::INTERVAL_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        prdata = '0;
        unique case (reg_idx)
            dfrs_pkg::REG_STREAM_IS_HEVC: begin
                prdata[0] = cfg_reg.stream_is_hevc;
            end
            dfrs_pkg::REG_TARGET_RATE_FPS: begin
                prdata[dfrs_pkg::FPS_W-1:0] = cfg_reg.target_rate_fps;
            end
            dfrs_pkg::REG_REFRESH_INTERVAL_MS: begin
                prdata[dfrs_pkg::INTERVAL_W-1:0] = cfg_reg.refresh_interval_ms;
            end
            default: begin
            end
        endcase
    end

endmodule

// ===== rtl/core/dfrs_decide.sv =====
// supervisor state and per-frame decision logic
module dfrs_decide (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  dfrs_pkg::dfrs_cfg_t             cfg,
    input  logic                            step,
    input  logic [dfrs_pkg::FEED_W-1:0]     feed_result,
    input  logic                            frame_is_key,
    input  logic [dfrs_pkg::TIME_W-1:0]     now_ms,
    output dfrs_pkg::dfrs_result_t          result
);

    logic [dfrs_pkg::ERR_W-1:0]    err_count_reg,   err_count_next;
    logic [dfrs_pkg::TIME_W-1:0]   err_start_reg,   err_start_next;
    logic [dfrs_pkg::TIME_W-1:0]   nr_start_reg,    nr_start_next;
    logic [dfrs_pkg::TIME_W-1:0]   last_key_reg,    last_key_next;
    logic [dfrs_pkg::FRAMES_W-1:0] frames_reg,      frames_next;
    logic                          resume_key_reg,  resume_key_next;

    logic [dfrs_pkg::FRAMES_W-1:0] frames_inc;
    logic [dfrs_pkg::PROD_W-1:0]   rate_prod;
    logic [dfrs_pkg::SCALE_W-1:0]  frames_scaled;
    logic                          refresh_due;
    logic                          err_restart;
    logic [dfrs_pkg::ERR_W-1:0]    err_base;
    logic [dfrs_pkg::ERR_W-1:0]    err_inc;

    // fps * interval + 500, then frames >= (that / 1000) rewritten as
    // (frames + 1) * 1000 > product so no divider is needed
    assign frames_inc = frame_is_key ? '0 :
                        (frames_reg == dfrs_pkg::FRAMES_MAX) ? frames_reg :
                        frames_reg + 1'b1;
    assign rate_prod = dfrs_pkg::PROD_W'(cfg.target_rate_fps * cfg.refresh_interval_ms)
                       + dfrs_pkg::ROUND_MS;
    assign frames_scaled = (dfrs_pkg::SCALE_W'(frames_inc) + 1'b1)
                           * dfrs_pkg::SCALE_W'(dfrs_pkg::MS_PER_S);
    assign refresh_due = cfg.stream_is_hevc
                         && (cfg.refresh_interval_ms >= dfrs_pkg::MIN_REFRESH_MS)
                         && (cfg.target_rate_fps != '0)
                         && (rate_prod >= dfrs_pkg::MS_PER_S)
                         && (frames_scaled > dfrs_pkg::SCALE_W'(rate_prod));

    assign err_restart = (err_count_reg == '0)
                         || ((now_ms - err_start_reg) > dfrs_pkg::ERROR_WINDOW_MS);
    assign err_base = err_restart ? '0 : err_count_reg;
    assign err_inc  = (err_base == dfrs_pkg::ERROR_LIMIT) ? err_base : err_base + 1'b1;

    always_comb begin
        err_count_next  = err_count_reg;
        err_start_next  = err_start_reg;
        nr_start_next   = nr_start_reg;
        last_key_next   = last_key_reg;
        frames_next     = frames_reg;
        resume_key_next = resume_key_reg;
        result          = '0;
        unique case (feed_result)
            dfrs_pkg::FEED_OK: begin
                err_count_next  = '0;
                nr_start_next   = '0;
                frames_next     = refresh_due ? '0 : frames_inc;
                result.refresh_request = refresh_due;
                result.reply    = resume_key_reg;
                resume_key_next = 1'b0;
            end
            dfrs_pkg::FEED_KEY_REQ: begin
                if ((last_key_reg == '0) || ((now_ms - last_key_reg) >= dfrs_pkg::KEY_GAP_MS)) begin
                    last_key_next = now_ms;
                    result.reply  = 1'b1;
                end
            end
            dfrs_pkg::FEED_NOT_READY: begin
                resume_key_next = 1'b1;
                if (nr_start_reg == '0) begin
                    nr_start_next = now_ms;
                end else if ((now_ms - nr_start_reg) > dfrs_pkg::WEDGE_MS) begin
                    nr_start_next = '0;
                    result.interrupt_session = 1'b1;
                end
            end
            dfrs_pkg::FEED_ERROR: begin
                if (err_restart) begin
                    err_start_next = now_ms;
                end
                err_count_next = err_inc;
                if (err_inc == dfrs_pkg::ERROR_LIMIT) begin
                    result.interrupt_session = 1'b1;
                end else begin
                    result.reply = 1'b1;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            err_count_reg  <= '0;
            err_start_reg  <= '0;
            nr_start_reg   <= '0;
            last_key_reg   <= '0;
            frames_reg     <= '0;
            resume_key_reg <= 1'b0;
        end else if (step) begin
            err_count_reg  <= err_count_next;
            err_start_reg  <= err_start_next;
            nr_start_reg   <= nr_start_next;
            last_key_reg   <= last_key_next;
            frames_reg     <= frames_next;
            resume_key_reg <= resume_key_next;
        end
    end

endmodule

// ===== rtl/core/decoder_feed_recovery_supervisor_unit.sv =====
// an accepted beat passes the input register and the result register to m_tdata
// throughput: one beat per cycle while m_tready is high; input register, one pass of
//   compare logic, result register; state updated in the same cycle as the result
// reset: aresetn synchronous active low; clears the pipeline valids, all
//   supervisor state, and loads the registers with their defaults
module decoder_feed_recovery_supervisor_unit (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [dfrs_pkg::TIME_W-1:0]       s_tdata,   // [31:0] now_ms
    input  logic [dfrs_pkg::S_USER_W-1:0]     s_tuser,   // [1:0] feed_result, [2] frame_is_key
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [dfrs_pkg::M_DATA_W-1:0]     m_tdata,   // [0] reply, [1] refresh_request,
                                                         // [2] interrupt_session, [7:3] zero
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [dfrs_pkg::APB_ADDR_W-1:0]   paddr,
    input  logic [dfrs_pkg::APB_DATA_W-1:0]   pwdata,
    output logic [dfrs_pkg::APB_DATA_W-1:0]   prdata,
    output logic                              pready
);

    dfrs_pkg::dfrs_cfg_t          cfg;
    dfrs_pkg::dfrs_result_t       result;

    logic                         in_valid_reg;
    logic [dfrs_pkg::FEED_W-1:0]  in_feed_reg;
    logic                         in_key_reg;
    logic [dfrs_pkg::TIME_W-1:0]  in_now_reg;
    logic                         out_valid_reg;
    dfrs_pkg::dfrs_result_t       out_result_reg;
    logic                         advance;

    // the input stage moves on whenever the result register is free or draining
    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    dfrs_regs u_regs (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    dfrs_decide u_decide (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg          (cfg),
        .step         (advance),
        .feed_result  (in_feed_reg),
        .frame_is_key (in_key_reg),
        .now_ms       (in_now_reg),
        .result       (result)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tvalid && s_tready) begin
            in_valid_reg <= 1'b1;
        end else if (advance) begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_feed_reg <= s_tuser[dfrs_pkg::FEED_W-1:0];
            in_key_reg  <= s_tuser[dfrs_pkg::FEED_W];
            in_now_reg  <= s_tdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_result_reg <= result;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {5'b0, out_result_reg.interrupt_session,
                       out_result_reg.refresh_request, out_result_reg.reply};

`ifndef SYNTH
    // a periodic refresh only follows a good feed, an interrupt never does
    a_refresh_not_with_interrupt: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !(m_tdata[1] && m_tdata[2]))
        else $error("refresh and interrupt raised on the same beat");

    // an interrupt replaces the key frame reply
    a_interrupt_without_reply: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tdata[2]) |-> !m_tdata[0])
        else $error("interrupt beat also asks for a key frame");

    // a beat in the input register while the output is free must move on next edge
    a_input_drains: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_valid_reg && !out_valid_reg) |=> out_valid_reg)
        else $error("input beat did not reach the result register");
`endif

endmodule
